// ----- src/psv_pkg.sv -----
package psv_pkg;

   localparam logic [31:0] MaxBytesReset   = 32'd1048576;
   localparam logic [15:0] PanelShortReset = 16'd400;
   localparam logic [15:0] PanelLongReset  = 16'd600;
   localparam logic [31:0] CrcPoly         = 32'hedb88320;

   typedef enum logic [2:0] {
      PH_SIG  = 3'd0,
      PH_HDR  = 3'd1,
      PH_DATA = 3'd2,
      PH_CRC  = 3'd3,
      PH_DONE = 3'd4,
      PH_FAIL = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE    = 2'd0,
      KIND_FINISH  = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      FC_NONE       = 4'd0,
      FC_INCOMPLETE = 4'd1,
      FC_BOUNDS     = 4'd2,
      FC_TRAILING   = 4'd3,
      FC_SIGNATURE  = 4'd4,
      FC_HEADER     = 4'd5,
      FC_IHDR_FIRST = 4'd6,
      FC_IHDR_DUP   = 4'd7,
      FC_CRITICAL   = 4'd8,
      FC_PLTE       = 4'd9,
      FC_IDAT       = 4'd10,
      FC_IEND       = 4'd11,
      FC_CRC        = 4'd12,
      FC_IHDR_FMT   = 4'd13
   } fail_type;

   localparam logic [1:0] CfgMaxBytes   = 2'd0;
   localparam logic [1:0] CfgPanelShort = 2'd1;
   localparam logic [1:0] CfgPanelLong  = 2'd2;

   typedef struct packed {
      logic       ok;
      logic       complete;
      logic [3:0] failure_code;
      logic       landscape;
      logic [7:0] color_type;
      logic       accepted;
   } result_type;

   localparam logic [7:0] SigByte0 = 8'h89;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] r;
      begin
         case (idx)
            3'd0: r = SigByte0;
            3'd1: r = 8'h50;
            3'd2: r = 8'h4e;
            3'd3: r = 8'h47;
            3'd4: r = 8'h0d;
            3'd5: r = 8'h0a;
            3'd6: r = 8'h1a;
            default: r = 8'h0a;
         endcase
         return r;
      end
   endfunction

   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] v);
      logic [31:0] c;
      begin
         c = c_in ^ {24'd0, v};
         for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
         end
         return c;
      end
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
   endfunction

endpackage

// ----- src/psv_core.sv -----
module psv_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [1:0]             kind,
   input  logic [7:0]             data_byte,
   input  logic [31:0]            expected_total,
   input  logic [31:0]            max_bytes,
   input  logic [15:0]            panel_short,
   input  logic [15:0]            panel_long,
   output psv_pkg::result_type    result
);

   psv_pkg::phase_type phase_ff, phase_in;
   logic [31:0] total_ff, total_in;
   logic [2:0]  sig_idx_ff, sig_idx_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  hdr_ff [8];
   logic [7:0]  hdr_in [8];
   logic [31:0] data_idx_ff, data_idx_in;
   logic [1:0]  crc_idx_ff, crc_idx_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] run_ff, run_in;
   logic [31:0] stored_ff, stored_in;
   logic [7:0]  ihdr_ff [13];
   logic [7:0]  ihdr_in [13];
   logic        of_ihdr_ff, of_ihdr_in, of_plte_ff, of_plte_in;
   logic        of_idat_ff, of_idat_in, of_closed_ff, of_closed_in;
   logic        complete_ff, complete_in, failed_ff, failed_in, land_ff, land_in;
   logic [3:0]  fail_ff, fail_in;
   logic [7:0]  colour_ff, colour_in;
   logic        accepted;

   // header view of the bytes, with the last header byte folded in
   logic [7:0]  hb [8];
   logic [31:0] len;
   logic        t_ihdr, t_plte, t_idat, t_iend, typ_ok, anc;
   logic [31:0] total_nx;
   logic [31:0] room;
   logic [31:0] hcrc;
   logic [31:0] w, h;
   logic        dims_ok, fmt_ok;
   logic [3:0]  len_dsum;
   logic        len_div3;

   function automatic logic is_letters();
      return psv_pkg::is_letter(hb[4]) && psv_pkg::is_letter(hb[5]) &&
             psv_pkg::is_letter(hb[6]) && psv_pkg::is_letter(hb[7]) &&
             hb[6] >= 8'h41 && hb[6] <= 8'h5a;
   endfunction

   function automatic logic cur_is(input logic [31:0] t);
      return {hdr_ff[4], hdr_ff[5], hdr_ff[6], hdr_ff[7]} == t;
   endfunction

   function automatic logic t_ihdr_cur();
      return cur_is(32'h49484452);
   endfunction

   always_comb begin
      for (int i = 0; i < 8; i++) hb[i] = hdr_ff[i];
      hb[7] = data_byte;
      len = {hb[0], hb[1], hb[2], hb[3]};
      typ_ok = is_letters();
      t_ihdr = {hb[4], hb[5], hb[6], hb[7]} == 32'h49484452;
      t_plte = {hb[4], hb[5], hb[6], hb[7]} == 32'h504c5445;
      t_idat = {hb[4], hb[5], hb[6], hb[7]} == 32'h49444154;
      t_iend = {hb[4], hb[5], hb[6], hb[7]} == 32'h49454e44;
      anc = hb[4][5];
      // byte count including the header byte now arriving
      total_nx = total_ff + 32'd1;
      room = max_bytes - total_nx;
      // multiple of 3 via base-4 digit sum; lengths above 768 fail anyway
      len_dsum = {2'd0, len[1:0]} + {2'd0, len[3:2]} + {2'd0, len[5:4]} +
                 {2'd0, len[7:6]} + {2'd0, len[9:8]};
      len_div3 = len_dsum == 4'd0 || len_dsum == 4'd3 || len_dsum == 4'd6 ||
                 len_dsum == 4'd9 || len_dsum == 4'd12 || len_dsum == 4'd15;
      hcrc = psv_pkg::crc_byte(psv_pkg::crc_byte(psv_pkg::crc_byte(psv_pkg::crc_byte(
         32'hffffffff, hb[4]), hb[5]), hb[6]), hb[7]);
      w = {ihdr_ff[0], ihdr_ff[1], ihdr_ff[2], ihdr_ff[3]};
      h = {ihdr_ff[4], ihdr_ff[5], ihdr_ff[6], ihdr_ff[7]};
      dims_ok = (w == {16'd0, panel_short} && h == {16'd0, panel_long}) ||
                (w == {16'd0, panel_long} && h == {16'd0, panel_short});
      case (ihdr_ff[9])
         8'd0: fmt_ok = ihdr_ff[8] == 8'd1 || ihdr_ff[8] == 8'd2 || ihdr_ff[8] == 8'd4 ||
                        ihdr_ff[8] == 8'd8 || ihdr_ff[8] == 8'd16;
         8'd2, 8'd4, 8'd6: fmt_ok = ihdr_ff[8] == 8'd8 || ihdr_ff[8] == 8'd16;
         8'd3: fmt_ok = ihdr_ff[8] == 8'd1 || ihdr_ff[8] == 8'd2 || ihdr_ff[8] == 8'd4 ||
                        ihdr_ff[8] == 8'd8;
         default: fmt_ok = 1'b0;
      endcase
      fmt_ok = fmt_ok && ihdr_ff[10] == 8'd0 && ihdr_ff[11] == 8'd0 && ihdr_ff[12] <= 8'd1;
   end

   always_comb begin
      phase_in = phase_ff; total_in = total_ff; sig_idx_in = sig_idx_ff;
      hdr_idx_in = hdr_idx_ff; data_idx_in = data_idx_ff; crc_idx_in = crc_idx_ff;
      size_in = size_ff; run_in = run_ff; stored_in = stored_ff;
      for (int i = 0; i < 8; i++) hdr_in[i] = hdr_ff[i];
      for (int i = 0; i < 13; i++) ihdr_in[i] = ihdr_ff[i];
      of_ihdr_in = of_ihdr_ff; of_plte_in = of_plte_ff;
      of_idat_in = of_idat_ff; of_closed_in = of_closed_ff;
      complete_in = complete_ff; failed_in = failed_ff; land_in = land_ff;
      fail_in = fail_ff; colour_in = colour_ff;
      accepted = 1'b0;

      case (psv_pkg::kind_type'(kind))
         psv_pkg::KIND_BYTE: begin
            if (failed_ff || complete_ff || total_ff >= max_bytes) begin
               failed_in = 1'b1; complete_in = 1'b0; phase_in = psv_pkg::PH_FAIL;
               fail_in = complete_ff ? psv_pkg::FC_TRAILING : psv_pkg::FC_BOUNDS;
            end else begin
               total_in = total_nx;
               case (phase_ff)
                  psv_pkg::PH_SIG: begin
                     if (data_byte != psv_pkg::sig_byte(sig_idx_ff)) begin
                        failed_in = 1'b1; phase_in = psv_pkg::PH_FAIL;
                        fail_in = psv_pkg::FC_SIGNATURE;
                     end else begin
                        sig_idx_in = sig_idx_ff + 3'd1;
                        if (sig_idx_ff == 3'd7) begin
                           phase_in = psv_pkg::PH_HDR; hdr_idx_in = 3'd0;
                        end
                     end
                  end
                  psv_pkg::PH_HDR: begin
                     hdr_in[hdr_idx_ff] = data_byte;
                     hdr_idx_in = hdr_idx_ff + 3'd1;
                     if (hdr_idx_ff == 3'd7) begin
                        size_in = len;
                        phase_in = psv_pkg::PH_FAIL;
                        failed_in = 1'b1;
                        // budget counts the last header byte already
                        if (!typ_ok || total_nx > max_bytes || room < 32'd4 ||
                            len > room - 32'd4)
                           fail_in = psv_pkg::FC_HEADER;
                        else if (!of_ihdr_ff && !t_ihdr) fail_in = psv_pkg::FC_IHDR_FIRST;
                        else if (t_ihdr && (of_ihdr_ff || len != 32'd13))
                           fail_in = psv_pkg::FC_IHDR_DUP;
                        else if (!t_ihdr && !t_plte && !t_idat && !t_iend && !anc)
                           fail_in = psv_pkg::FC_CRITICAL;
                        else if (t_plte && (of_plte_ff || of_idat_ff || len == 32'd0 ||
                                 len > 32'd768 || !len_div3 ||
                                 colour_ff == 8'd0 || colour_ff == 8'd4))
                           fail_in = psv_pkg::FC_PLTE;
                        else if (t_idat && (!of_ihdr_ff || of_closed_ff || len == 32'd0 ||
                                 (colour_ff == 8'd3 && !of_plte_ff)))
                           fail_in = psv_pkg::FC_IDAT;
                        else if (t_iend && (len != 32'd0 || !of_idat_ff))
                           fail_in = psv_pkg::FC_IEND;
                        else begin
                           failed_in = failed_ff; fail_in = fail_ff;
                           if (of_idat_ff && !t_idat && !t_iend) of_closed_in = 1'b1;
                           run_in = hcrc; data_idx_in = 32'd0; crc_idx_in = 2'd0;
                           stored_in = 32'd0;
                           phase_in = (len == 32'd0) ? psv_pkg::PH_CRC : psv_pkg::PH_DATA;
                        end
                     end
                  end
                  psv_pkg::PH_DATA: begin
                     run_in = psv_pkg::crc_byte(run_ff, data_byte);
                     if (t_ihdr_cur() && data_idx_ff < 32'd13)
                        ihdr_in[data_idx_ff[3:0]] = data_byte;
                     data_idx_in = data_idx_ff + 32'd1;
                     if (data_idx_in == size_ff) begin
                        phase_in = psv_pkg::PH_CRC; crc_idx_in = 2'd0; stored_in = 32'd0;
                     end
                  end
                  psv_pkg::PH_CRC: begin
                     stored_in = {stored_ff[23:0], data_byte};
                     crc_idx_in = crc_idx_ff + 2'd1;
                     if (crc_idx_ff == 2'd3) begin
                        if (stored_in != ~run_ff) begin
                           failed_in = 1'b1; phase_in = psv_pkg::PH_FAIL;
                           fail_in = psv_pkg::FC_CRC;
                        end else begin
                           phase_in = psv_pkg::PH_HDR; hdr_idx_in = 3'd0;
                           if (cur_is(32'h49484452)) begin
                              if (dims_ok) colour_in = ihdr_ff[9];
                              if (!dims_ok || !fmt_ok) begin
                                 failed_in = 1'b1; phase_in = psv_pkg::PH_FAIL;
                                 fail_in = psv_pkg::FC_IHDR_FMT;
                              end else begin
                                 land_in = w == {16'd0, panel_long};
                                 of_ihdr_in = 1'b1;
                              end
                           end else if (cur_is(32'h504c5445)) of_plte_in = 1'b1;
                           else if (cur_is(32'h49444154)) of_idat_in = 1'b1;
                           else if (cur_is(32'h49454e44)) begin
                              complete_in = 1'b1; phase_in = psv_pkg::PH_DONE;
                           end
                        end
                     end
                  end
                  default: begin
                     failed_in = 1'b1; phase_in = psv_pkg::PH_FAIL;
                     fail_in = psv_pkg::FC_HEADER;
                  end
               endcase
            end
         end
         psv_pkg::KIND_FINISH: begin
            accepted = !failed_ff && complete_ff && of_ihdr_ff && of_idat_ff &&
                       phase_ff == psv_pkg::PH_DONE && total_ff == expected_total;
         end
         psv_pkg::KIND_RESTART: begin
            phase_in = psv_pkg::PH_SIG; total_in = 32'd0; sig_idx_in = 3'd0;
            hdr_idx_in = 3'd0; data_idx_in = 32'd0; crc_idx_in = 2'd0; size_in = 32'd0;
            run_in = 32'hffffffff; stored_in = 32'd0;
            for (int i = 0; i < 8; i++) hdr_in[i] = 8'd0;
            for (int i = 0; i < 13; i++) ihdr_in[i] = 8'd0;
            of_ihdr_in = 1'b0; of_plte_in = 1'b0; of_idat_in = 1'b0; of_closed_in = 1'b0;
            complete_in = 1'b0; failed_in = 1'b0; land_in = 1'b0;
            fail_in = psv_pkg::FC_NONE; colour_in = 8'hff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= psv_pkg::PH_SIG; total_ff <= 32'd0; sig_idx_ff <= 3'd0;
         hdr_idx_ff <= 3'd0; data_idx_ff <= 32'd0; crc_idx_ff <= 2'd0; size_ff <= 32'd0;
         run_ff <= 32'hffffffff; stored_ff <= 32'd0;
         for (int i = 0; i < 8; i++) hdr_ff[i] <= 8'd0;
         for (int i = 0; i < 13; i++) ihdr_ff[i] <= 8'd0;
         of_ihdr_ff <= 1'b0; of_plte_ff <= 1'b0; of_idat_ff <= 1'b0; of_closed_ff <= 1'b0;
         complete_ff <= 1'b0; failed_ff <= 1'b0; land_ff <= 1'b0;
         fail_ff <= psv_pkg::FC_NONE; colour_ff <= 8'hff;
         result <= '0;
      end else if (step) begin
         phase_ff <= phase_in; total_ff <= total_in; sig_idx_ff <= sig_idx_in;
         hdr_idx_ff <= hdr_idx_in; data_idx_ff <= data_idx_in; crc_idx_ff <= crc_idx_in;
         size_ff <= size_in; run_ff <= run_in; stored_ff <= stored_in;
         for (int i = 0; i < 8; i++) hdr_ff[i] <= hdr_in[i];
         for (int i = 0; i < 13; i++) ihdr_ff[i] <= ihdr_in[i];
         of_ihdr_ff <= of_ihdr_in; of_plte_ff <= of_plte_in;
         of_idat_ff <= of_idat_in; of_closed_ff <= of_closed_in;
         complete_ff <= complete_in; failed_ff <= failed_in; land_ff <= land_in;
         fail_ff <= fail_in; colour_ff <= colour_in;
         result.ok <= !failed_in;
         result.complete <= complete_in;
         result.failure_code <= failed_in ? fail_in :
                                (complete_in ? psv_pkg::FC_NONE : psv_pkg::FC_INCOMPLETE);
         result.landscape <= land_in;
         result.color_type <= colour_in;
         result.accepted <= accepted;
      end
   end

endmodule

// ----- src/png_stream_validator.sv -----
// png byte stream checker: one beat per cycle unless rsp_tready stalls the output
// register; each request beat yields one response beat in the next cycle, from the
// single register stage around the byte-wide crc-32 update and the chunk checks.
// kind 0 feeds a file byte, kind 1 asks for the accept verdict against expected_total,
// kind 2 clears all validator state; configuration registers survive a restart. the
// response reports the status after the beat: failure code (later bytes overwrite it
// with FC_BOUNDS), complete after a clean iend, ihdr orientation and colour type.
module png_stream_validator #(
   parameter logic [31:0] MaxBytesInit   = psv_pkg::MaxBytesReset,
   parameter logic [15:0] PanelShortInit = psv_pkg::PanelShortReset,
   parameter logic [15:0] PanelLongInit  = psv_pkg::PanelLongReset
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], expected_total[39:8]
   input  logic [1:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // ok, complete, failure_code, landscape,
                                    // color_type, accepted
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0] max_bytes_ff;
   logic [15:0] panel_short_ff, panel_long_ff;
   logic        valid_ff;
   logic        step;
   psv_pkg::result_type res;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MaxBytesInit;
         panel_short_ff <= PanelShortInit;
         panel_long_ff <= PanelLongInit;
      end else if (csr_we) begin
         if (csr_index == psv_pkg::CfgMaxBytes) max_bytes_ff <= csr_wdata;
         else if (csr_index == psv_pkg::CfgPanelShort)
            panel_short_ff <= csr_wdata[15:0];
         else if (csr_index == psv_pkg::CfgPanelLong)
            panel_long_ff <= csr_wdata[15:0];
      end
   end

   // output register: take a new beat whenever the slot is empty or draining
   assign req_tready = !valid_ff || rsp_tready;
   assign step = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (req_tready) valid_ff <= req_tvalid;
   end

   psv_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .kind           (req_tuser),
      .data_byte      (req_tdata[7:0]),
      .expected_total (req_tdata[39:8]),
      .max_bytes      (max_bytes_ff),
      .panel_short    (panel_short_ff),
      .panel_long     (panel_long_ff),
      .result         (res)
   );

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {res.accepted, res.color_type, res.landscape,
                       res.failure_code, res.complete, res.ok};

endmodule
